### hw/rtl/tasm_pkg.sv
// Package for the threshold alert state machine.
// Holds the shared types, codes and constants; it depends on nothing else.
`timescale 1ns / 1ps

package tasm_pkg;

	localparam int CFG_ADDR_BITS = 5;
	localparam int DELAY_BITS = 26;
	localparam int OCC_BITS = 8;
	localparam int ID_BITS = 8;
	localparam int LEVEL_BITS = 32;

	localparam logic [OCC_BITS-1:0] OCC_WRAP_ABOVE = 8'd250;
	localparam logic [DELAY_BITS-1:0] SILENCE_RESET_MS = 26'd3600000;

	typedef enum logic [1:0] {
		FN_SAMPLE   = 2'd0,
		FN_RESPONSE = 2'd1,
		FN_TICK     = 2'd2,
		FN_UNUSED   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CMD_ACK      = 2'd0,
		CMD_SILENCE  = 2'd1,
		CMD_TEST_OFF = 2'd2,
		CMD_TEST_ON  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_GT   = 2'd0,
		MODE_LT   = 2'd1,
		MODE_EQ   = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STS_NORMAL   = 2'd0,
		STS_EXCEEDED = 2'd1,
		STS_ACKED    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ALR_NORMAL   = 2'd0,
		ALR_ACTIVE   = 2'd1,
		ALR_SILENCED = 2'd2,
		ALR_ACKED    = 2'd3
	} alert_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_LEVEL     = 3'd1,
		REG_DELAY     = 3'd2,
		REG_SYSTEM    = 3'd3,
		REG_SUBSYSTEM = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t                  mode;
		logic [LEVEL_BITS-1:0]  level;
		logic [DELAY_BITS-1:0]  delay;
		logic [ID_BITS-1:0]     system;
		logic [ID_BITS-1:0]     subsystem;
	} cfg_t;

	typedef struct packed {
		status_t                status;
		alert_t                 alert;
		logic [OCC_BITS-1:0]    occ;
		logic                   silence;
		logic                   ack;
		logic [DELAY_BITS-1:0]  countdown;
	} alert_state_t;

endpackage

### hw/rtl/threshold_alert_state_machine.sv
// Top level of the threshold alert state machine: register port, handshakes, state.
// Depends on tasm_pkg and instantiates tasm_next.
`timescale 1ns / 1ps

// Each item (a sample test, an alert response or a millisecond tick) is applied to the
// alert state registers, which double as the result register; one item can be taken in
// every cycle while results are taken as fast. The next item is taken in the same cycle
// as the waiting result leaves; it waits only when the result is stalled. The user must
// write registers through the APB port only while no transfer is in flight (not enforced).
module threshold_alert_state_machine
	import tasm_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic [1:0]               func,
	input  logic [31:0]              sample_value,
	input  logic [ID_BITS-1:0]       resp_system,
	input  logic [ID_BITS-1:0]       resp_subsystem,
	input  logic [1:0]               resp_command,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic [1:0]               threshold_status,
	output logic [1:0]               alert_state,
	output logic [OCC_BITS-1:0]      occurrence_count,
	output logic                     silence_on,
	output logic                     ack_on,
	output logic                     response_matched
);

	cfg_t         cfg_q;
	alert_state_t st_q;
	alert_state_t st_nxt;
	logic         matched_nxt;
	logic         matched_q;
	logic         valid_q;
	logic         item_xfer;
	logic         cfg_wr;
	logic [2:0]   reg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[CFG_ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_GT;
			cfg_q.level <= '0;
			cfg_q.delay <= SILENCE_RESET_MS;
			cfg_q.system <= '0;
			cfg_q.subsystem <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:      cfg_q.mode <= mode_t'(pwdata[1:0]);
				REG_LEVEL:     cfg_q.level <= pwdata;
				REG_DELAY:     cfg_q.delay <= pwdata[DELAY_BITS-1:0];
				REG_SYSTEM:    cfg_q.system <= pwdata[ID_BITS-1:0];
				REG_SUBSYSTEM: cfg_q.subsystem <= pwdata[ID_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:      prdata = {30'd0, cfg_q.mode};
			REG_LEVEL:     prdata = cfg_q.level;
			REG_DELAY:     prdata = {6'd0, cfg_q.delay};
			REG_SYSTEM:    prdata = {24'd0, cfg_q.system};
			REG_SUBSYSTEM: prdata = {24'd0, cfg_q.subsystem};
			default:       prdata = '0;
		endcase
	end

	assign item_ready = !valid_q || result_ready;
	assign item_xfer = item_valid && item_ready;

	tasm_next #(
		.VALUE_BITS(VALUE_BITS)
	) u_next (
		.cfg(cfg_q),
		.cur(st_q),
		.func(func),
		.sample_value(sample_value),
		.resp_system(resp_system),
		.resp_subsystem(resp_subsystem),
		.resp_command(resp_command),
		.nxt(st_nxt),
		.matched(matched_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.status <= STS_NORMAL;
			st_q.alert <= ALR_NORMAL;
			st_q.occ <= '0;
			st_q.silence <= 1'b0;
			st_q.ack <= 1'b0;
			st_q.countdown <= '0;
			matched_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (item_xfer) begin
				st_q <= st_nxt;
				matched_q <= matched_nxt;
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign threshold_status = st_q.status;
	assign alert_state = st_q.alert;
	assign occurrence_count = st_q.occ;
	assign silence_on = st_q.silence;
	assign ack_on = st_q.ack;
	assign response_matched = matched_q;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.occ <= 8'd251)
		else $error("Occurrence count left its range.");

	a_acked_has_ack: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.status == STS_ACKED |-> st_q.ack)
		else $error("Acknowledged status without an acknowledge flag.");

	a_acked_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.alert == ALR_ACKED) == (st_q.status == STS_ACKED))
		else $error("Alert state and threshold status disagree on acknowledge.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !result_ready |-> !item_xfer)
		else $error("A transfer was taken over a stalled result.");

endmodule

### hw/rtl/tasm_next.sv
// Next-state logic of the threshold alert: applies one item to the alert state.
// Depends on tasm_pkg for the state, configuration and code types.
`timescale 1ns / 1ps

module tasm_next
	import tasm_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  cfg_t                cfg,
	input  alert_state_t        cur,
	input  logic [1:0]          func,
	input  logic [31:0]         sample_value,
	input  logic [ID_BITS-1:0]  resp_system,
	input  logic [ID_BITS-1:0]  resp_subsystem,
	input  logic [1:0]          resp_command,
	output alert_state_t        nxt,
	output logic                matched
);

	localparam int CMP_BITS = (VALUE_BITS < LEVEL_BITS) ? VALUE_BITS : LEVEL_BITS;

	logic [CMP_BITS-1:0] value_c;
	logic [CMP_BITS-1:0] level_c;
	logic                hit;
	logic [OCC_BITS-1:0] occ_base;
	alert_state_t        hit_st;

	assign value_c = sample_value[CMP_BITS-1:0];
	assign level_c = cfg.level[CMP_BITS-1:0];

	always_comb begin
		unique case (cfg.mode)
			MODE_GT: hit = value_c > level_c;
			MODE_LT: hit = value_c < level_c;
			MODE_EQ: hit = value_c == level_c;
			default: hit = 1'b0;
		endcase
	end

	always_comb begin
		occ_base = (cur.occ > OCC_WRAP_ABOVE) ? '0 : cur.occ;
		hit_st = cur;
		hit_st.occ = occ_base;
		if (cur.status == STS_NORMAL) begin
			hit_st.status = STS_EXCEEDED;
			hit_st.occ = occ_base + 8'd1;
		end
		if (hit_st.status == STS_EXCEEDED) begin
			hit_st.alert = ALR_ACTIVE;
			if (cur.silence) begin
				hit_st.alert = ALR_SILENCED;
			end
			if (cur.ack) begin
				hit_st.alert = ALR_ACKED;
				hit_st.status = STS_ACKED;
			end
		end
	end

	always_comb begin
		nxt = cur;
		matched = 1'b0;
		unique case (func_t'(func))
			FN_SAMPLE: begin
				if (cfg.mode != MODE_NONE) begin
					if (hit) begin
						nxt = hit_st;
					end else begin
						nxt.status = STS_NORMAL;
						nxt.alert = ALR_NORMAL;
						nxt.ack = 1'b0;
					end
				end
				if (cur.countdown == '0) begin
					nxt.silence = 1'b0;
				end
			end
			FN_RESPONSE: begin
				matched = (resp_system == cfg.system) && (resp_subsystem == cfg.subsystem);
				if (matched) begin
					if (cmd_t'(resp_command) == CMD_ACK) begin
						nxt.ack = 1'b1;
					end else if (cmd_t'(resp_command) == CMD_SILENCE) begin
						nxt.silence = 1'b1;
						nxt.countdown = cfg.delay;
					end
				end
			end
			FN_TICK: begin
				if (cur.countdown != '0) begin
					nxt.countdown = cur.countdown - 26'd1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
